// File: sv/u8gd_pkg.sv
// ----------------------------------------------------------------------------
// u8gd_pkg
// Shared types and constants for the UTF-8 glyph decoder.
// ----------------------------------------------------------------------------
package u8gd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 21;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned HIST_D  = 3;

    // Result kinds carried on the output tuser
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_GLYPH   = 2'd1,
        KIND_CODEPT  = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    // Byte class masks and patterns
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LEAD_C3    = 8'hC3;
    localparam logic [7:0] C3_OFFSET  = 8'h40;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
    localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4    = 3'd4;
    localparam logic [CNT_W-1:0] POS_MAX  = 3'd7;

    // Running sequence state; hist[0] is the most recent byte
    typedef struct packed {
        logic [CNT_W-1:0]                  seq_length;
        logic [CNT_W-1:0]                  seq_position;
        logic [HIST_D-1:0][BYTE_W-1:0]     hist;
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
    } result_t;

endpackage

// File: sv/utf8_glyph_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_glyph_decoder_unit
// Streaming UTF-8 to glyph / code point decoder.
// ----------------------------------------------------------------------------
// Takes one message byte per request on the slave side and gives exactly one
// result per byte on the master side (kind "nothing" included). Throughput is
// one byte per clock while m_tready is high; each byte passes through the input
// register and then the result register. The rate is set by the loop through
// the sequence state (length, position, last three bytes) that each byte
// updates as it moves from the input register to the result register.
// Set s_tuser on the first byte of a message to clear the sequence state.
// ASCII gives a glyph (LF and CR map to space), C2/C3 two-byte sequences give
// Latin-1 glyphs, three and four byte sequences give a code point on their
// last byte, other two-byte leads and bytes F8..FF give an invalid result.
// No range checks are done on decoded code points.
// ----------------------------------------------------------------------------
module utf8_glyph_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] first_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] out_value, [23:21] zero
    output logic [1:0]  m_tuser    // [1:0] out_kind
);
    import u8gd_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    // sequence state
    state_t     state_reg;
    state_t     state_next;
    result_t    step_result;

    // result register
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic out_free;
    logic advance;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    u8gd_step u_step (
        .in_byte          (in_byte_reg),
        .first_of_message (in_first_reg),
        .state_cur        (state_reg),
        .state_next       (state_next),
        .result           (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    // state advances only when the byte's result is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg  <= step_result.kind;
            out_value_reg <= step_result.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_value_reg};
    assign m_tuser  = out_kind_reg;

    // nothing and invalid results carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_INVALID) |-> m_tdata == 24'd0)
        else $error("nonzero value on a nothing/invalid result");

    // an open sequence always has a nonzero position
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.seq_length != LEN_NONE) |-> (state_reg.seq_position != 3'd0))
        else $error("sequence length set with zero position");

    // the length is only ever none, 2, 3 or 4
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seq_length == LEN_NONE || state_reg.seq_length == LEN_2 ||
        state_reg.seq_length == LEN_3 || state_reg.seq_length == LEN_4)
        else $error("illegal sequence length");

    // a byte F8..FF gives an invalid result and closes the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_byte_reg[7:3] == 5'b11111) |=>
            m_tvalid && m_tuser == KIND_INVALID && state_reg.seq_length == LEN_NONE)
        else $error("bad lead byte not flagged");

endmodule

// File: sv/u8gd_step.sv
// ----------------------------------------------------------------------------
// u8gd_step
// One decode step: current state and byte in, next state and result out.
// ----------------------------------------------------------------------------
module u8gd_step (
    input  logic [7:0]         in_byte,
    input  logic               first_of_message,
    input  u8gd_pkg::state_t   state_cur,
    output u8gd_pkg::state_t   state_next,
    output u8gd_pkg::result_t  result
);
    import u8gd_pkg::*;

    state_t          st;
    logic [CNT_W-1:0] pos_inc;
    logic [7:0]      c3_glyph;

    // a message start clears the sequence state before the byte is handled
    assign st       = first_of_message ? '0 : state_cur;
    assign pos_inc  = (st.seq_position < POS_MAX) ? st.seq_position + 3'd1 : st.seq_position;
    assign c3_glyph = in_byte + C3_OFFSET;

    always_comb
    begin
        state_next         = st;
        state_next.hist    = {st.hist[1], st.hist[0], in_byte};
        result.kind        = KIND_NONE;
        result.value       = '0;

        priority if ((in_byte & ASCII_MASK) == 8'h00)
        begin
            state_next.seq_length   = LEN_NONE;
            state_next.seq_position = '0;
            result.kind             = KIND_GLYPH;
            result.value            = (in_byte == CHAR_LF || in_byte == CHAR_CR)
                                      ? {13'd0, CHAR_SPACE} : {13'd0, in_byte};
        end
        else if ((in_byte & CONT_MASK) == CONT_PAT)
        begin
            state_next.seq_position = pos_inc;
            priority if (pos_inc == 3'd2 && st.seq_length == LEN_2)
            begin
                priority if (st.hist[0] == LEAD_C2)
                begin
                    result.kind  = KIND_GLYPH;
                    result.value = {13'd0, in_byte};
                end
                else if (st.hist[0] == LEAD_C3)
                begin
                    result.kind  = KIND_GLYPH;
                    result.value = {13'd0, c3_glyph};
                end
                else
                begin
                    result.kind  = KIND_INVALID;
                end
            end
            else if (pos_inc == 3'd3 && st.seq_length == LEN_3)
            begin
                result.kind  = KIND_CODEPT;
                result.value = {5'd0, st.hist[1][3:0], st.hist[0][5:0], in_byte[5:0]};
            end
            else if (pos_inc == 3'd4 && st.seq_length == LEN_4)
            begin
                result.kind  = KIND_CODEPT;
                result.value = {st.hist[2][2:0], st.hist[1][5:0],
                                st.hist[0][5:0], in_byte[5:0]};
            end
            else
            begin
                result.kind  = KIND_NONE;
            end
        end
        else if ((in_byte & LEAD2_MASK) == LEAD2_PAT)
        begin
            state_next.seq_length   = LEN_2;
            state_next.seq_position = 3'd1;
        end
        else if ((in_byte & LEAD3_MASK) == LEAD3_PAT)
        begin
            state_next.seq_length   = LEN_3;
            state_next.seq_position = 3'd1;
        end
        else if ((in_byte & LEAD4_MASK) == LEAD4_PAT)
        begin
            state_next.seq_length   = LEN_4;
            state_next.seq_position = 3'd1;
        end
        else
        begin
            // F8..FF: not a valid lead
            state_next.seq_length   = LEN_NONE;
            state_next.seq_position = '0;
            result.kind             = KIND_INVALID;
        end
    end

endmodule
